/* rtl/lfu_cache_with_lru_ties_macros.svh */
// assertion macros for the lfu cache
`ifndef LFU_CACHE_WITH_LRU_TIES_MACROS_SVH
`define LFU_CACHE_WITH_LRU_TIES_MACROS_SVH
`define LFU_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lfu check failed");
`define LFU_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lfu check failed");
`endif

/* rtl/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types and constants of the lfu cache
// ----------------------------------------------------------------------------
package lfu_pkg;
  localparam int KEY_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [KEY_W-1:0] MISS_VALUE = '1;
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic clear;
    logic scan;
    logic apply;
  } lfu_cmd_t;

  typedef struct packed {
    logic scan_last;
  } lfu_sts_t;
endpackage

/* rtl/lfu_datapath.sv */
// ----------------------------------------------------------------------------
// lfu_datapath
// entry storage, sequential scan for match, victim and free slot, update
// ----------------------------------------------------------------------------
module lfu_datapath import lfu_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lfu_cmd_t                cmd,
  output lfu_sts_t                sts,
  input  logic [CAP_W-1:0]        capacity,
  input  logic                    mode,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [KEY_W-1:0] value,
  output logic                    res_hit,
  output logic [KEY_W-1:0]        res_read_value,
  output logic                    res_evicted,
  output logic [KEY_W-1:0]        res_evicted_key
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int RW = IW;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic                  valid_r [ENTRIES];
  logic [KEY_W-1:0]      key_r   [ENTRIES];
  logic [KEY_W-1:0]      val_r   [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_r   [ENTRIES];
  logic [RW-1:0]         rank_r  [ENTRIES];

  logic [IW-1:0]         idx_r;
  logic                  found_r, vic_ok_r, free_ok_r;
  logic [IW-1:0]         found_idx_r, vic_idx_r, free_idx_r;
  logic [COUNT_BITS-1:0] vic_cnt_r;
  logic [RW-1:0]         vic_rank_r;
  logic [OW-1:0]         occ_r;

  logic [OW-1:0] cap_eff;
  assign cap_eff = (int'(capacity) > ENTRIES) ? OW'(ENTRIES) : OW'(capacity);
  assign sts.scan_last = (idx_r == IW'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      idx_r <= '0;
      found_r <= 1'b0;
      vic_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
      occ_r <= '0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + IW'(1);
      if (valid_r[idx_r]) begin
        occ_r <= occ_r + OW'(1);
        if (!found_r && key_r[idx_r] == key) begin
          found_r <= 1'b1;
          found_idx_r <= idx_r;
        end
        if (!vic_ok_r || cnt_r[idx_r] < vic_cnt_r ||
            (cnt_r[idx_r] == vic_cnt_r && rank_r[idx_r] > vic_rank_r)) begin
          vic_ok_r <= 1'b1;
          vic_idx_r <= idx_r;
          vic_cnt_r <= cnt_r[idx_r];
          vic_rank_r <= rank_r[idx_r];
        end
      end else if (!free_ok_r) begin
        free_ok_r <= 1'b1;
        free_idx_r <= idx_r;
      end
    end
  end

  logic do_touch, do_insert, do_evict;
  logic [IW-1:0] ins_idx;
  logic [RW-1:0] touch_rank;
  assign do_touch  = found_r && (mode == MODE_GET || cap_eff != '0);
  assign do_evict  = (mode == MODE_PUT) && cap_eff != '0 && !found_r &&
                     occ_r >= cap_eff && vic_ok_r;
  assign do_insert = (mode == MODE_PUT) && cap_eff != '0 && !found_r &&
                     (do_evict || free_ok_r);
  assign ins_idx   = do_evict ? vic_idx_r : free_idx_r;
  assign touch_rank = rank_r[found_idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) valid_r[i] <= 1'b0;
    end else if (cmd.apply) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_touch) begin
          if (IW'(i) == found_idx_r) begin
            rank_r[i] <= '0;
            if (cnt_r[i] != CMAX) cnt_r[i] <= cnt_r[i] + COUNT_BITS'(1);
            if (mode == MODE_PUT) val_r[i] <= value;
          end else if (valid_r[i] && rank_r[i] < touch_rank) begin
            rank_r[i] <= rank_r[i] + RW'(1);
          end
        end else if (do_insert) begin
          if (IW'(i) == ins_idx) begin
            valid_r[i] <= 1'b1;
            key_r[i] <= key;
            val_r[i] <= value;
            cnt_r[i] <= COUNT_BITS'(1);
            rank_r[i] <= '0;
          end else if (valid_r[i] && !(do_evict && rank_r[i] > vic_rank_r)) begin
            rank_r[i] <= rank_r[i] + RW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_hit <= found_r;
      res_read_value <= (found_r && mode == MODE_GET) ? val_r[found_idx_r] : MISS_VALUE;
      res_evicted <= do_evict;
      res_evicted_key <= do_evict ? key_r[vic_idx_r] : '0;
    end
  end
endmodule

/* rtl/lfu_ctrl.sv */
// ----------------------------------------------------------------------------
// lfu_ctrl
// sequencer: accept, scan, apply, hold result until taken
// ----------------------------------------------------------------------------
`include "lfu_cache_with_lru_ties_macros.svh"
module lfu_ctrl import lfu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output logic     take,
  output lfu_cmd_t cmd,
  input  lfu_sts_t sts
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign take = in_valid && state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.clear = 1'b1;
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `LFU_ASSERT_NEXT(a_take_scan, take, state_r == S_SCAN)
  `LFU_ASSERT_NEXT(a_apply_out, cmd.apply, out_valid)
  `LFU_ASSERT_IMPL(a_no_accept_busy, out_valid, in_stall)
endmodule

/* rtl/lfu_cache_with_lru_ties.sv */
// sequence: accept, a scan over every entry, the apply state, then the result is held valid
// one transaction at a time: a new request is accepted only after the previous result is taken
// reset: synchronous active low; entries invalid, capacity 16
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_ties
// key-value cache, lfu replacement with lru tie break
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_ties import lfu_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CAP_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_mode,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic signed [KEY_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic signed [KEY_W-1:0] out_read_value,
  output logic                    out_evicted,
  output logic signed [KEY_W-1:0] out_evicted_key
);
  logic [CAP_W-1:0] cap_r;
  logic mode_r;
  logic [KEY_W-1:0] key_r, val_r;
  logic take;
  lfu_cmd_t cmd;
  lfu_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= in_mode;
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  lfu_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .take, .cmd, .sts
  );

  lfu_datapath #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .capacity(cap_r), .mode(mode_r),
    .key(key_r), .value(val_r),
    .res_hit(out_hit), .res_read_value(out_read_value),
    .res_evicted(out_evicted), .res_evicted_key(out_evicted_key)
  );
endmodule

/* dv/lfu_cache_with_lru_ties_checker.sv */
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_ties_checker
// watches the request and result channels, keeps its own copy of the cache
// contents, use counts and recency order, and compares every result
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_ties_checker import lfu_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CAP_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_mode,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic signed [KEY_W-1:0] in_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_hit,
  input  logic signed [KEY_W-1:0] out_read_value,
  input  logic                    out_evicted,
  input  logic [KEY_W-1:0]        out_evicted_key,
  output int                      fail_count,
  output int                      pending,
  output int                      hit_seen,
  output int                      evict_seen
);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } lookup_result_t;

  logic [CAP_W-1:0]      cap_reg;
  logic                  slot_valid [ENTRIES];
  logic [KEY_W-1:0]      slot_key   [ENTRIES];
  logic [KEY_W-1:0]      slot_data  [ENTRIES];
  logic [COUNT_BITS-1:0] slot_uses  [ENTRIES];
  int                    slot_age   [ENTRIES];
  lookup_result_t        expected_results [$];

  assign pending = expected_results.size();

  task automatic report(input string what, input logic [KEY_W-1:0] got,
                        input logic [KEY_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic void mark_recent(input int s);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
    if (slot_uses[s] != COUNT_MAX) slot_uses[s]++;
  endfunction

  function automatic lookup_result_t apply_request(input logic mode,
      input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] data);
    lookup_result_t r;
    int found, occupied, victim, target, limit;
    found = -1; occupied = 0; victim = -1; target = -1;
    limit = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
    r = '{hit: 1'b0, read_value: MISS_VALUE, evicted: 1'b0, evicted_key: '0};
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i]) begin
        occupied++;
        if (found < 0 && slot_key[i] == key) found = i;
      end
    r.hit = (found >= 0);
    if (mode == MODE_GET) begin
      if (found >= 0) begin
        mark_recent(found);
        r.read_value = slot_data[found];
      end
    end else if (limit != 0) begin
      if (found >= 0) begin
        slot_data[found] = data;
        mark_recent(found);
      end else begin
        if (occupied >= limit)
          for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
              victim = i;
        if (victim >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[victim];
          slot_valid[victim] = 1'b0;
          for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_age[i] > slot_age[victim]) slot_age[i]--;
          target = victim;
        end else begin
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!slot_valid[i]) target = i;
        end
        if (target >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i]) slot_age[i]++;
          slot_valid[target] = 1'b1;
          slot_key[target] = key;
          slot_data[target] = data;
          slot_uses[target] = 1;
          slot_age[target] = 0;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      cap_reg <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_uses[i] = '0;
        slot_age[i] = 0;
      end
      expected_results.delete();
      fail_count <= 0;
      hit_seen <= 0;
      evict_seen <= 0;
    end else begin
      if (cfg_we) cap_reg <= cfg_wdata;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected result transaction", '0, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_hit !== want.hit) report("hit", out_hit, want.hit);
          if (out_read_value !== want.read_value)
            report("read_value", out_read_value, want.read_value);
          if (out_evicted !== want.evicted) report("evicted", out_evicted, want.evicted);
          if (out_evicted_key !== want.evicted_key)
            report("evicted_key", out_evicted_key, want.evicted_key);
          if (want.hit) hit_seen++;
          if (want.evicted) evict_seen++;
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_request(in_mode, in_key, in_value));
    end
  end
endmodule

/* dv/lfu_cache_with_lru_ties_tb.sv */
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_ties_tb
// drives directed and random get/put traffic over several capacities and
// idling patterns; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_ties_tb;
  import lfu_pkg::*;

  localparam int   LATENCY = 19;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_mode = MODE_GET;
  logic signed [KEY_W-1:0] in_key = '0;
  logic signed [KEY_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_hit;
  logic signed [KEY_W-1:0] out_read_value;
  logic                    out_evicted;
  logic signed [KEY_W-1:0] out_evicted_key;
  int                      fail_count, pending, hit_seen, evict_seen;
  int                      send_idle_pct = 0;
  int                      stall_pct = 0;
  int                      hold_cycles = 0;
  int                      sent = 0;
  logic [KEY_W-1:0]        key_pool [8];

  always #5 clk = ~clk;

  lfu_cache_with_lru_ties DUT (.*);

  lfu_cache_with_lru_ties_checker checker_i (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .in_mode, .in_key,
    .in_value, .out_valid, .out_stall, .out_hit, .out_read_value, .out_evicted,
    .out_evicted_key, .fail_count, .pending, .hit_seen, .evict_seen
  );

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send(input logic mode, input logic [KEY_W-1:0] key,
                      input logic [KEY_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_key   <= key;
    in_value <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(9) == 0) ? $urandom() : key_pool[3'($urandom_range(7))];
      if ($urandom_range(3) == 0) k = $urandom_range(19);
      send(1'($urandom_range(1)), k, $urandom());
    end
  endtask

  initial begin
    #20000000;
    $display("timeout");
    $display("lfu_cache_with_lru_ties_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();

    // directed: extremes, updates, saturation-free ties, eviction, zero capacity
    send(MODE_GET, 32'h8000_0000, 0);
    send(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send(MODE_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send(MODE_PUT, 32'h0, 32'h0);
    send(MODE_GET, 32'h7fff_ffff, 0);
    send(MODE_PUT, 32'h0, 32'h1234_5678);
    send(MODE_GET, 32'h0, 0);
    set_capacity(CAP_W'(2));
    send(MODE_PUT, 32'h55, 1);
    send(MODE_PUT, 32'haa, 2);
    send(MODE_GET, 32'h55, 0);
    send(MODE_PUT, 32'hcc, 3);
    set_capacity(CAP_W'(0));
    send(MODE_PUT, 32'hdd, 4);
    send(MODE_GET, 32'hcc, 0);
    send(MODE_PUT, 32'hcc, 5);
    set_capacity(CAP_W'(31));
    for (int i = 0; i < 18; i++) send(MODE_PUT, i, ~i);

    // random phases over capacities and idling patterns
    set_capacity(CAP_W'(1));  random_phase(100);
    set_capacity(CAP_W'(4));  send_idle_pct = 77; random_phase(100);
    set_capacity(CAP_W'(16)); send_idle_pct = 0; stall_pct = 77; random_phase(120);
    set_capacity(CAP_W'(3));  send_idle_pct = 37; stall_pct = 37; random_phase(100);
    // long hold-off while requests keep coming
    set_capacity(CAP_W'(8));  send_idle_pct = 0; stall_pct = 0;
    hold_cycles = 400;
    random_phase(60);
    drain();
    random_phase(100);
    set_capacity(CAP_W'(0));  random_phase(40);
    set_capacity(CAP_W'(17)); stall_pct = 20; random_phase(150);

    drain();
    $display("sent %0d requests, %0d hits, %0d evictions, capacities 0 to 31",
             sent, hit_seen, evict_seen);
    if (fail_count == 0)
      $display("lfu_cache_with_lru_ties_tb: done, clean");
    else
      $display("lfu_cache_with_lru_ties_tb: done, errors");
    $finish;
  end
endmodule
